### hdl/bfbp_pkg.sv
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared constants and types of the best-fit buffer pool: pool depth,
// index widths, operation codes, entry layout and the command and result
// words passed between the top level and the engine.
// ----------------------------------------------------------------------------
package bfbp_pkg;

    localparam int MAX_ENTRIES = 12;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [31:0] BUDGET_RESET = 32'd805306368;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] capacity;
    } entry_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] request_bytes;
        logic [31:0] released_capacity;
        logic [15:0] released_handle;
    } cmd_t;

    typedef struct packed {
        logic        granted;
        logic [15:0] granted_handle;
        logic [31:0] granted_capacity;
        logic        must_grow;
        logic        kept;
        logic [3:0]  entries_now;
        logic [31:0] bytes_now;
    } res_t;

endpackage

### hdl/best_fit_buffer_pool.sv
// Release, clear, an unused op and an acquire on an empty pool go straight from ST_IDLE
// to ST_DONE; any other acquire passes ST_SCAN, ST_PICK and ST_SHIFT first. The result
// is loaded into the output register from ST_DONE once res_ready is high. One word is
// in flight: a new word is taken only in ST_IDLE, and the engine also waits while
// m_tready low holds the result in the output register.
// reset: synchronous active-low, empties the pool and sets byte_budget to 805306368
// ----------------------------------------------------------------------------
// best_fit_buffer_pool
// Pool of buffer handles with best-fit acquire, budgeted release and clear,
// stream input and output with a registered result word.
// ----------------------------------------------------------------------------
module best_fit_buffer_pool
    import bfbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,      // byte_budget
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,       // request_bytes, released_capacity, released_handle
    input  logic [1:0]  s_tuser,       // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata        // granted, granted_handle, granted_capacity,
                                       // must_grow, kept, entries_now, bytes_now, pad
);

    logic [31:0] budget_reg;
    logic        m_valid_reg;
    logic [87:0] m_data_reg;
    cmd_t        cmd;
    res_t        res;
    logic        res_valid;
    logic        res_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= BUDGET_RESET;
        end else if (cfg_valid) begin
            budget_reg <= cfg_data;
        end
    end

    assign cmd.op                = s_tuser;
    assign cmd.request_bytes     = s_tdata[31:0];
    assign cmd.released_capacity = s_tdata[63:32];
    assign cmd.released_handle   = s_tdata[79:64];

    bfbp_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (s_tvalid),
        .cmd_ready   (s_tready),
        .cmd         (cmd),
        .byte_budget (budget_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= {1'b0, res.bytes_now, res.entries_now, res.kept, res.must_grow,
                           res.granted_capacity, res.granted_handle, res.granted};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### hdl/bfbp_ram.sv
// ----------------------------------------------------------------------------
// bfbp_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bfbp_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 12,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

### hdl/bfbp_engine.sv
// ----------------------------------------------------------------------------
// bfbp_engine
// Sequencer around the entry memory: scans the pool for the best-fit or
// largest entry, removes it by moving later entries up one place, appends
// released buffers and keeps the entry count and pooled byte total.
// ----------------------------------------------------------------------------
module bfbp_engine
    import bfbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    input  logic [31:0] byte_budget,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_PICK  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      total_reg, total_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [31:0]      req_reg, req_next;

    logic             fit_found_reg, fit_found_next;
    logic [IDX_W-1:0] fit_idx_reg, fit_idx_next;
    entry_t           fit_ent_reg, fit_ent_next;
    logic             max_found_reg, max_found_next;
    logic [IDX_W-1:0] max_idx_reg, max_idx_next;
    entry_t           max_ent_reg, max_ent_next;

    logic             granted_reg, granted_next;
    logic [15:0]      ghandle_reg, ghandle_next;
    logic [31:0]      gcap_reg, gcap_next;
    logic             grow_reg, grow_next;
    logic             kept_reg, kept_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t           rd_ent;
    logic [32:0]      rel_sum;
    logic [IDX_W-1:0] sel_idx;
    entry_t           sel_ent;

    bfbp_ram #(
        .DATA_W ($bits(entry_t)),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_ent  = entry_t'(ram_rdata);
    assign rel_sum = {1'b0, total_reg} + {1'b0, cmd.released_capacity};
    assign sel_idx = fit_found_reg ? fit_idx_reg : max_idx_reg;
    assign sel_ent = fit_found_reg ? fit_ent_reg : max_ent_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        req_next        = req_reg;
        fit_found_next  = fit_found_reg;
        fit_idx_next    = fit_idx_reg;
        fit_ent_next    = fit_ent_reg;
        max_found_next  = max_found_reg;
        max_idx_next    = max_idx_reg;
        max_ent_next    = max_ent_reg;
        granted_next    = granted_reg;
        ghandle_next    = ghandle_reg;
        gcap_next       = gcap_reg;
        grow_next       = grow_reg;
        kept_next       = kept_reg;
        ram_we          = 1'b0;
        ram_waddr       = IDX_W'(count_reg);
        ram_wdata       = '{handle: cmd.released_handle, capacity: cmd.released_capacity};
        ram_raddr       = IDX_W'(issue_reg);
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    granted_next = 1'b0;
                    ghandle_next = '0;
                    gcap_next    = '0;
                    grow_next    = 1'b0;
                    kept_next    = 1'b0;
                    state_next   = ST_DONE;
                    case (cmd.op)
                        OP_ACQUIRE: begin
                            if (count_reg != '0) begin
                                req_next       = cmd.request_bytes;
                                issue_next     = '0;
                                fit_found_next = 1'b0;
                                max_found_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        OP_RELEASE: begin
                            if (cmd.released_capacity != '0 &&
                                count_reg < CNT_W'(MAX_ENTRIES) &&
                                rel_sum <= {1'b0, byte_budget}) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                total_next = rel_sum[31:0];
                                kept_next  = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            total_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (issue_reg < count_reg) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg;
                    issue_next      = issue_reg + CNT_W'(1);
                end
                if (pend_valid_reg) begin
                    // strict compares keep the earliest entry on ties
                    if (rd_ent.capacity >= req_reg &&
                        (!fit_found_reg || rd_ent.capacity < fit_ent_reg.capacity)) begin
                        fit_found_next = 1'b1;
                        fit_idx_next   = IDX_W'(pend_idx_reg);
                        fit_ent_next   = rd_ent;
                    end
                    if (!max_found_reg || rd_ent.capacity > max_ent_reg.capacity) begin
                        max_found_next = 1'b1;
                        max_idx_next   = IDX_W'(pend_idx_reg);
                        max_ent_next   = rd_ent;
                    end
                end
                if (issue_reg == count_reg && !pend_valid_reg) begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK: begin
                granted_next = 1'b1;
                ghandle_next = sel_ent.handle;
                gcap_next    = sel_ent.capacity;
                grow_next    = (sel_ent.capacity < req_reg);
                total_next   = (total_reg > sel_ent.capacity) ?
                               (total_reg - sel_ent.capacity) : '0;
                issue_next   = CNT_W'(sel_idx) + CNT_W'(1);
                state_next   = ST_SHIFT;
            end

            ST_SHIFT: begin
                // read entry k+1 ahead while entry k is written back
                if (issue_reg < count_reg) begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg;
                    issue_next      = issue_reg + CNT_W'(1);
                end
                if (pend_valid_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(pend_idx_reg - CNT_W'(1));
                    ram_wdata = rd_ent;
                end
                if (issue_reg == count_reg && !pend_valid_reg) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg     <= issue_next;
        pend_idx_reg  <= pend_idx_next;
        req_reg       <= req_next;
        fit_found_reg <= fit_found_next;
        fit_idx_reg   <= fit_idx_next;
        fit_ent_reg   <= fit_ent_next;
        max_found_reg <= max_found_next;
        max_idx_reg   <= max_idx_next;
        max_ent_reg   <= max_ent_next;
        granted_reg   <= granted_next;
        ghandle_reg   <= ghandle_next;
        gcap_reg      <= gcap_next;
        grow_reg      <= grow_next;
        kept_reg      <= kept_next;
    end

    always_comb begin
        res.granted          = granted_reg;
        res.granted_handle   = ghandle_reg;
        res.granted_capacity = gcap_reg;
        res.must_grow        = grow_reg;
        res.kept             = kept_reg;
        res.entries_now      = 4'(count_reg);
        res.bytes_now        = total_reg;
    end

endmodule

### verif/best_fit_buffer_pool_checker.sv
// ----------------------------------------------------------------------------
// best_fit_buffer_pool_checker
// Watches the budget, command and result channels of the buffer pool. It keeps
// its own copy of the pooled entries, the byte total and the budget, and works
// out the result word for every accepted command. Each accepted result word is
// compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module best_fit_buffer_pool_checker
    import bfbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);

    logic [31:0] slot_capacity [MAX_ENTRIES];
    logic [15:0] slot_handle   [MAX_ENTRIES];
    int          slot_count;
    logic [31:0] pool_bytes;
    logic [31:0] budget;
    res_t        pending_results [$];

    function automatic res_t pool_step(input cmd_t c);
        res_t r;
        int   k;
        int   pick;
        logic found;
        r     = '0;
        pick  = 0;
        found = 1'b0;
        case (c.op)
            OP_ACQUIRE: begin
                // smallest covering entry, earliest on a tie
                for (k = 0; k < slot_count; k++) begin
                    if (slot_capacity[k] >= c.request_bytes &&
                        (!found || slot_capacity[k] < slot_capacity[pick])) begin
                        pick  = k;
                        found = 1'b1;
                    end
                end
                // nothing covers: earliest largest, must grow
                if (!found && slot_count > 0) begin
                    pick = 0;
                    for (k = 1; k < slot_count; k++) begin
                        if (slot_capacity[k] > slot_capacity[pick]) pick = k;
                    end
                    found = 1'b1;
                end
                if (found) begin
                    r.granted          = 1'b1;
                    r.granted_handle   = slot_handle[pick];
                    r.granted_capacity = slot_capacity[pick];
                    r.must_grow        = slot_capacity[pick] < c.request_bytes;
                    pool_bytes = (pool_bytes > slot_capacity[pick]) ?
                                 pool_bytes - slot_capacity[pick] : 32'd0;
                    for (k = pick; k < slot_count - 1; k++) begin
                        slot_capacity[k] = slot_capacity[k + 1];
                        slot_handle[k]   = slot_handle[k + 1];
                    end
                    slot_count--;
                end
            end
            OP_RELEASE: begin
                // budget sum is formed one bit wider so it cannot wrap
                if (c.released_capacity != 0 && slot_count < MAX_ENTRIES &&
                    {1'b0, pool_bytes} + {1'b0, c.released_capacity} <= {1'b0, budget}) begin
                    slot_capacity[slot_count] = c.released_capacity;
                    slot_handle[slot_count]   = c.released_handle;
                    slot_count++;
                    pool_bytes = pool_bytes + c.released_capacity;
                    r.kept     = 1'b1;
                end
            end
            OP_CLEAR: begin
                slot_count = 0;
                pool_bytes = '0;
            end
            default: begin
            end
        endcase
        r.entries_now = 4'(slot_count);
        r.bytes_now   = pool_bytes;
        return r;
    endfunction

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : watch
        cmd_t c;
        res_t got;
        res_t want;
        int   bad;
        if (!aresetn) begin
            slot_count = 0;
            pool_bytes = '0;
            budget     = BUDGET_RESET;
            fail_count = 0;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) budget = cfg_data;
            if (s_tvalid && s_tready) begin
                c.op                = s_tuser;
                c.request_bytes     = s_tdata[31:0];
                c.released_capacity = s_tdata[63:32];
                c.released_handle   = s_tdata[79:64];
                pending_results.push_back(pool_step(c));
            end
            if (m_tvalid && m_tready) begin
                got.granted          = m_tdata[0];
                got.granted_handle   = m_tdata[16:1];
                got.granted_capacity = m_tdata[48:17];
                got.must_grow        = m_tdata[49];
                got.kept             = m_tdata[50];
                got.entries_now      = m_tdata[54:51];
                got.bytes_now        = m_tdata[86:55];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got 0x%0h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    bad  = 0;
                    bad += field_mismatch("granted", want.granted, got.granted);
                    bad += field_mismatch("granted_handle", want.granted_handle,
                                          got.granted_handle);
                    bad += field_mismatch("granted_capacity", want.granted_capacity,
                                          got.granted_capacity);
                    bad += field_mismatch("must_grow", want.must_grow, got.must_grow);
                    bad += field_mismatch("kept", want.kept, got.kept);
                    bad += field_mismatch("entries_now", want.entries_now, got.entries_now);
                    bad += field_mismatch("bytes_now", want.bytes_now, got.bytes_now);
                    if (bad != 0) fail_count++;
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

### verif/best_fit_buffer_pool_tb.sv
// ----------------------------------------------------------------------------
// best_fit_buffer_pool_tb
// Drives the buffer pool with a directed run of corner cases (empty pool,
// zero and oversized releases, ties, must-grow, full pool, budget edge) and
// then random acquire/release/clear traffic under several byte budgets, with
// random gaps on both stream sides. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module best_fit_buffer_pool_tb;
    import bfbp_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         NUM_PHASES    = 6;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic [79:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [87:0] m_tdata;

    int   fail_count;
    int   outstanding;
    int   cycle_count;
    logic steady = 1'b0;

    always #1 aclk = ~aclk;

    best_fit_buffer_pool u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    best_fit_buffer_pool_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 19);
    end

    // called at a falling edge; leaves tvalid high so the next word can follow
    task automatic send_word(input logic [1:0] op, input logic [31:0] req,
                             input logic [31:0] cap, input logic [15:0] handle);
        int gap;
        gap = (!steady && $urandom_range(99) < 19) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {handle, cap, req};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_budget(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_capacity(input logic [31:0] budget);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            3:       return (budget == 0) ? 32'd1 : $urandom_range(budget, 1);
            default: return 32'(64 * $urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [31:0] pick_request();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom();
            default: return 32'(64 * $urandom_range(0, 17)) + 32'($urandom_range(0, 2)) - 32'd1;
        endcase
    endfunction

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] phase_budget [NUM_PHASES];
        int          phase_items  [NUM_PHASES];
        int          p;
        int          n;
        int          k;
        int          pick;
        logic [31:0] budget;
        phase_budget = '{BUDGET_RESET, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd0, BUDGET_RESET};
        phase_items  = '{150, 150, 40, 150, 135, 100};
        phase_budget[4] = $urandom();

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        send_word(OP_ACQUIRE, 32'd5, '0, '0);               // empty pool miss
        send_word(OP_RELEASE, '0, '0, 16'h1234);            // zero capacity ignored
        send_word(OP_RELEASE, '0, 32'hFFFF_FFFF, 16'hFFFF); // over budget
        send_word(OP_RELEASE, '0, 32'd100, 16'd1);
        send_word(OP_RELEASE, '0, 32'd50, 16'd2);
        send_word(OP_RELEASE, '0, 32'd100, 16'd3);
        send_word(OP_RELEASE, '0, 32'd200, 16'd0);
        send_word(OP_ACQUIRE, 32'd60, '0, '0);              // tie on 100, earliest wins
        send_word(OP_ACQUIRE, 32'hFFFF_FFFF, '0, '0);       // nothing covers, must grow
        send_word(OP_ACQUIRE, 32'd0, '0, '0);
        send_word(OP_UNUSED, '1, '1, '1);
        send_word(OP_CLEAR, '1, '1, '1);
        for (k = 0; k < MAX_ENTRIES + 1; k++) begin          // last one hits a full pool
            send_word(OP_RELEASE, '0, 32'h0100_0000 + 32'(k), 16'(k));
        end
        send_word(OP_CLEAR, '0, '0, '0);

        // exact budget edge, then a lower budget that leaves the pool alone
        drain_results();
        write_budget(32'd300);
        send_word(OP_RELEASE, '0, 32'd300, 16'hA5A5);
        send_word(OP_RELEASE, '0, 32'd1, 16'h5A5A);
        drain_results();
        write_budget(32'd100);
        send_word(OP_ACQUIRE, 32'd10, '0, '0);

        for (p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            budget = phase_budget[p];
            write_budget(budget);
            steady = (p == 1);
            for (n = 0; n < phase_items[p]; n++) begin
                if (n % 100 == 99) drain_results();
                pick = $urandom_range(99);
                if (pick < 42)
                    send_word(OP_ACQUIRE, pick_request(), $urandom(), 16'($urandom()));
                else if (pick < 88)
                    send_word(OP_RELEASE, $urandom(), pick_capacity(budget),
                              16'($urandom()));
                else if (pick < 94)
                    send_word(OP_CLEAR, $urandom(), $urandom(), 16'($urandom()));
                else
                    send_word(OP_UNUSED, $urandom(), $urandom(), 16'($urandom()));
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/bfbp_pkg.sv
hdl/bfbp_ram.sv
hdl/bfbp_engine.sv
hdl/best_fit_buffer_pool.sv
verif/best_fit_buffer_pool_checker.sv
verif/best_fit_buffer_pool_tb.sv
